/* rtl/isr_pkg.sv */
// ----------------------------------------------------------------------------
// isr_pkg
// types and constants shared by the segmentation and reassembly link
// ----------------------------------------------------------------------------
package isr_pkg;

    // input word
    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] frame_data;
        logic [3:0]  frame_length;
        logic [11:0] byte_index;
        logic [7:0]  byte_value;
        logic [15:0] length_value;
    } t_in_item;

    // result word
    typedef struct packed {
        logic [2:0]  status;
        logic        tx_valid;
        logic [63:0] tx_frame;
        logic [28:0] tx_can_id;
        logic        rx_ready;
        logic [11:0] rx_length;
        logic [7:0]  read_byte;
        logic        tx_busy;
    } t_out_item;

    // classified command
    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_RX_FRAME,
        CMD_LOAD_TX,
        CMD_START,
        CMD_READ_RX,
        CMD_RELEASE,
        CMD_IGNORE,
        CMD_BAD
    } t_cmd;

    // raw command codes
    localparam logic [2:0] RAW_TICK    = 3'd0;
    localparam logic [2:0] RAW_RX      = 3'd1;
    localparam logic [2:0] RAW_LOAD    = 3'd2;
    localparam logic [2:0] RAW_START   = 3'd3;
    localparam logic [2:0] RAW_READ    = 3'd4;
    localparam logic [2:0] RAW_RELEASE = 3'd5;

    // job handed from front to back
    typedef struct packed {
        t_cmd     cmd;
        t_in_item item;
    } t_job;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ERROR    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_NO_DATA  = 3'd4;

    // frame constants
    localparam logic [63:0] PAD_FRAME = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [3:0]  PCI_SF    = 4'h0;
    localparam logic [3:0]  PCI_FF    = 4'h1;
    localparam logic [3:0]  PCI_CF    = 4'h2;
    localparam logic [3:0]  PCI_FC    = 4'h3;
    localparam logic [3:0]  FC_CTS    = 4'h0;
    localparam logic [3:0]  FC_ABORT  = 4'h2;
    localparam logic [2:0]  CF_BYTES  = 3'd7;
    localparam logic [2:0]  FF_BYTES  = 3'd6;

    typedef enum logic [1:0] {
        TXP_IDLE,
        TXP_WAIT_FC,
        TXP_SEND_CF
    } t_txph;

    typedef enum logic {
        RXP_IDLE,
        RXP_RECV
    } t_rxph;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DECODE,
        BS_ISSUE,
        BS_CAPTURE,
        BS_RESULT
    } t_bstate;

    typedef enum logic [2:0] {
        LM_NONE,
        LM_TX_RD,
        LM_TX_WR,
        LM_RX_RD,
        LM_RX_WR
    } t_lmode;

endpackage

/* rtl/isr_if.sv */
// ----------------------------------------------------------------------------
// isr_in_if / isr_out_if
// valid/ready channels carrying input and result words
// ----------------------------------------------------------------------------
interface isr_in_if;
    logic              valid;
    logic              ready;
    isr_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface isr_out_if;
    logic               valid;
    logic               ready;
    isr_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/isr_front.sv */
// ----------------------------------------------------------------------------
// isr_front
// accepts input words, classifies the command, queues jobs for the engine
// ----------------------------------------------------------------------------
module isr_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    isr_in_if.sink       i_in,
    output isr_pkg::t_job o_job,
    output logic         o_job_valid,
    input  logic         i_job_pop
);

    isr_pkg::t_job r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    isr_pkg::t_cmd w_cmd;
    logic          w_push;

    // command classification
    always_comb begin
        case (i_in.payload.command)
            isr_pkg::RAW_TICK:    w_cmd = isr_pkg::CMD_TICK;
            isr_pkg::RAW_RX:      w_cmd = (i_in.payload.frame_length != 4'd0) ?
                                          isr_pkg::CMD_RX_FRAME : isr_pkg::CMD_IGNORE;
            isr_pkg::RAW_LOAD:    w_cmd = isr_pkg::CMD_LOAD_TX;
            isr_pkg::RAW_START:   w_cmd = isr_pkg::CMD_START;
            isr_pkg::RAW_READ:    w_cmd = isr_pkg::CMD_READ_RX;
            isr_pkg::RAW_RELEASE: w_cmd = isr_pkg::CMD_RELEASE;
            default:              w_cmd = isr_pkg::CMD_BAD;
        endcase
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{cmd: w_cmd, item: i_in.payload};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_job_pop};
        end
    end

endmodule

/* rtl/isr_back.sv */
// ----------------------------------------------------------------------------
// isr_back
// link engine: protocol state, byte buffers and result register
// ----------------------------------------------------------------------------
module isr_back #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  isr_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  logic [28:0]   i_send_id,
    input  logic [15:0]   i_timeout,
    isr_out_if.source     o_out
);

    localparam int          AW       = $clog2(BUFFER_BYTES);
    localparam logic [16:0] BUF_L    = 17'(BUFFER_BYTES);
    localparam logic [15:0] MAX_SEND = 16'((BUFFER_BYTES < 4095) ? BUFFER_BYTES : 4095);

    // buffers
    logic [7:0] tx_mem [BUFFER_BYTES];
    logic [7:0] rx_mem [BUFFER_BYTES];
    logic [7:0] r_tx_rd;
    logic [7:0] r_rx_rd;

    isr_pkg::t_bstate r_state, n_state;
    isr_pkg::t_job    r_job;

    // protocol state
    isr_pkg::t_txph r_tx_ph;
    logic [15:0]    r_tx_total;
    logic [15:0]    r_tx_done;
    logic [3:0]     r_tx_seq;
    logic [7:0]     r_tx_bs;
    logic [7:0]     r_tx_sep;
    logic [31:0]    r_tx_fc_stamp;
    logic [31:0]    r_tx_cf_stamp;
    isr_pkg::t_rxph r_rx_ph;
    logic [11:0]    r_rx_total;
    logic [11:0]    r_rx_got;
    logic [3:0]     r_rx_seq;
    logic [31:0]    r_rx_stamp;
    logic [31:0]    r_now;

    // per-word working registers
    logic [2:0]       r_status;
    logic             r_emit;
    logic [63:0]      r_frame;
    logic [7:0]       r_rbyte;
    logic             r_released;
    logic [11:0]      r_rel_len;
    isr_pkg::t_lmode  r_lmode;
    logic [15:0]      r_lbase;
    logic [2:0]       r_lcnt;
    logic [2:0]       r_k;
    logic [2:0]       r_lpos;
    logic             r_oob;

    logic                 r_res_valid;
    isr_pkg::t_out_item   r_res;

    // decode helpers
    logic [63:0] w_d;
    logic [3:0]  w_ptype;
    logic [3:0]  w_low;
    logic [11:0] w_ff_len;
    logic [31:0] w_nowp;
    logic [15:0] w_tx_rem;
    logic [2:0]  w_tx_n;
    logic [15:0] w_tx_done_nx;
    logic [11:0] w_rx_rem;
    logic [2:0]  w_rx_n;
    logic [11:0] w_rx_got_nx;
    logic        w_cf_due;
    logic        w_fc_to;
    logic        w_rx_to;
    logic        w_rx_rdy;
    logic [16:0] w_idx;
    logic        w_inb;
    logic [AW-1:0] w_addr;
    logic [2:0]  w_sel;
    logic [2:0]  w_put;
    logic [7:0]  w_fbyte;
    logic        w_tx_we;
    logic        w_rx_we;
    logic        w_loop_done;
    logic        w_res_load;
    logic [7:0]  w_cap;

    assign w_d          = r_job.item.frame_data;
    assign w_ptype      = w_d[63:60];
    assign w_low        = w_d[59:56];
    assign w_ff_len     = {w_low, w_d[55:48]};
    assign w_nowp       = r_now + 32'd1;
    assign w_tx_rem     = (r_tx_total > r_tx_done) ? (r_tx_total - r_tx_done) : 16'd0;
    assign w_tx_n       = (w_tx_rem > 16'd7) ? isr_pkg::CF_BYTES : w_tx_rem[2:0];
    assign w_tx_done_nx = r_tx_done + {13'd0, w_tx_n};
    assign w_rx_rem     = (r_rx_total > r_rx_got) ? (r_rx_total - r_rx_got) : 12'd0;
    assign w_rx_n       = (w_rx_rem > 12'd7) ? isr_pkg::CF_BYTES : w_rx_rem[2:0];
    assign w_rx_got_nx  = r_rx_got + {9'd0, w_rx_n};
    assign w_cf_due     = (w_nowp - r_tx_cf_stamp) >= {24'd0, r_tx_sep};
    assign w_fc_to      = (w_nowp - r_tx_fc_stamp) >= {16'd0, i_timeout};
    assign w_rx_to      = (w_nowp - r_rx_stamp) >= {16'd0, i_timeout};
    assign w_rx_rdy     = (r_rx_ph == isr_pkg::RXP_IDLE) && (r_rx_got != 12'd0)
                          && (r_rx_total != 12'd0);

    // buffer access for the byte loop
    assign w_idx       = {1'b0, r_lbase} + {14'd0, r_k};
    assign w_inb       = w_idx < BUF_L;
    assign w_addr      = w_idx[AW-1:0];
    assign w_sel       = r_lpos + r_k;
    assign w_fbyte     = w_d[{~w_sel, 3'b000} +: 8];
    assign w_loop_done = (r_k == r_lcnt);
    assign w_tx_we     = (r_state == isr_pkg::BS_ISSUE) && !w_loop_done
                         && (r_lmode == isr_pkg::LM_TX_WR) && w_inb;
    assign w_rx_we     = (r_state == isr_pkg::BS_ISSUE) && !w_loop_done
                         && (r_lmode == isr_pkg::LM_RX_WR) && w_inb;
    assign w_put       = r_lpos + r_k;
    assign w_cap       = r_oob ? 8'd0 :
                         ((r_lmode == isr_pkg::LM_RX_RD) ? r_rx_rd : r_tx_rd);

    always_ff @(posedge i_clk) begin
        if (w_tx_we) begin
            tx_mem[w_addr] <= r_job.item.byte_value;
        end
        r_tx_rd <= tx_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_we) begin
            rx_mem[w_addr] <= w_fbyte;
        end
        r_rx_rd <= rx_mem[w_addr];
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        w_res_load = 1'b0;
        case (r_state)
            isr_pkg::BS_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = isr_pkg::BS_DECODE;
                end
            end
            isr_pkg::BS_DECODE: n_state = isr_pkg::BS_ISSUE;
            isr_pkg::BS_ISSUE: begin
                if (w_loop_done) begin
                    n_state = isr_pkg::BS_RESULT;
                end else if (r_lmode == isr_pkg::LM_TX_RD || r_lmode == isr_pkg::LM_RX_RD) begin
                    n_state = isr_pkg::BS_CAPTURE;
                end
            end
            isr_pkg::BS_CAPTURE: n_state = isr_pkg::BS_ISSUE;
            isr_pkg::BS_RESULT: begin
                if (!r_res_valid || o_out.ready) begin
                    w_res_load = 1'b1;
                    n_state    = isr_pkg::BS_IDLE;
                end
            end
            default: n_state = isr_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isr_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload of the current word
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            isr_pkg::BS_DECODE: begin
                r_status   <= isr_pkg::ST_OK;
                r_emit     <= 1'b0;
                r_frame    <= isr_pkg::PAD_FRAME;
                r_rbyte    <= 8'd0;
                r_released <= 1'b0;
                r_rel_len  <= r_rx_total;
                r_lmode    <= isr_pkg::LM_NONE;
                r_lbase    <= 16'd0;
                r_lcnt     <= 3'd0;
                r_k        <= 3'd0;
                r_lpos     <= 3'd1;
                case (r_job.cmd)
                    isr_pkg::CMD_TICK: begin
                        if (r_tx_ph == isr_pkg::TXP_SEND_CF && w_cf_due) begin
                            r_emit  <= 1'b1;
                            r_frame <= {isr_pkg::PCI_CF, r_tx_seq, isr_pkg::PAD_FRAME[55:0]};
                            r_lmode <= isr_pkg::LM_TX_RD;
                            r_lbase <= r_tx_done;
                            r_lcnt  <= w_tx_n;
                        end
                    end
                    isr_pkg::CMD_RX_FRAME: begin
                        case (w_ptype)
                            isr_pkg::PCI_SF: begin
                                if (w_low != 4'd0 && w_low <= 4'd7) begin
                                    r_lmode <= isr_pkg::LM_RX_WR;
                                    r_lcnt  <= w_low[2:0];
                                end
                            end
                            isr_pkg::PCI_FF: begin
                                if (w_ff_len >= 12'd8) begin
                                    r_emit <= 1'b1;
                                    if ({5'd0, w_ff_len} > BUF_L) begin
                                        r_frame <= {isr_pkg::PCI_FC, isr_pkg::FC_ABORT, 16'd0,
                                                    isr_pkg::PAD_FRAME[39:0]};
                                    end else begin
                                        r_frame <= {isr_pkg::PCI_FC, isr_pkg::FC_CTS, 16'd0,
                                                    isr_pkg::PAD_FRAME[39:0]};
                                        r_lmode <= isr_pkg::LM_RX_WR;
                                        r_lcnt  <= isr_pkg::FF_BYTES;
                                        r_lpos  <= 3'd2;
                                    end
                                end
                            end
                            isr_pkg::PCI_CF: begin
                                if (r_rx_ph == isr_pkg::RXP_RECV && w_low == r_rx_seq) begin
                                    r_lmode <= isr_pkg::LM_RX_WR;
                                    r_lbase <= {4'd0, r_rx_got};
                                    r_lcnt  <= w_rx_n;
                                end
                            end
                            default: ;
                        endcase
                    end
                    isr_pkg::CMD_LOAD_TX: begin
                        if ({5'd0, r_job.item.byte_index} < BUF_L) begin
                            r_lmode <= isr_pkg::LM_TX_WR;
                            r_lbase <= {4'd0, r_job.item.byte_index};
                            r_lcnt  <= 3'd1;
                        end else begin
                            r_status <= isr_pkg::ST_ERROR;
                        end
                    end
                    isr_pkg::CMD_START: begin
                        if (r_job.item.length_value == 16'd0) begin
                            r_status <= isr_pkg::ST_ERROR;
                        end else if (r_job.item.length_value > MAX_SEND) begin
                            r_status <= isr_pkg::ST_OVERFLOW;
                        end else if (r_tx_ph != isr_pkg::TXP_IDLE) begin
                            r_status <= isr_pkg::ST_BUSY;
                        end else if (r_job.item.length_value <= 16'd7) begin
                            r_emit  <= 1'b1;
                            r_frame <= {r_job.item.length_value[7:0], isr_pkg::PAD_FRAME[55:0]};
                            r_lmode <= isr_pkg::LM_TX_RD;
                            r_lcnt  <= r_job.item.length_value[2:0];
                        end else begin
                            r_emit  <= 1'b1;
                            r_frame <= {isr_pkg::PCI_FF, r_job.item.length_value[11:0],
                                        isr_pkg::PAD_FRAME[47:0]};
                            r_lmode <= isr_pkg::LM_TX_RD;
                            r_lcnt  <= isr_pkg::FF_BYTES;
                            r_lpos  <= 3'd2;
                        end
                    end
                    isr_pkg::CMD_READ_RX: begin
                        if ({5'd0, r_job.item.byte_index} < BUF_L) begin
                            r_lmode <= isr_pkg::LM_RX_RD;
                            r_lbase <= {4'd0, r_job.item.byte_index};
                            r_lcnt  <= 3'd1;
                        end else begin
                            r_status <= isr_pkg::ST_ERROR;
                        end
                    end
                    isr_pkg::CMD_RELEASE: begin
                        if (!w_rx_rdy) begin
                            r_status <= isr_pkg::ST_NO_DATA;
                        end else if ({4'd0, r_rx_total} > r_job.item.length_value) begin
                            r_status <= isr_pkg::ST_OVERFLOW;
                        end else begin
                            r_released <= 1'b1;
                        end
                    end
                    isr_pkg::CMD_IGNORE: ;
                    default: r_status <= isr_pkg::ST_ERROR;
                endcase
            end
            isr_pkg::BS_ISSUE: begin
                r_oob <= !w_inb;
                if (!w_loop_done && (r_lmode == isr_pkg::LM_TX_WR
                                     || r_lmode == isr_pkg::LM_RX_WR)) begin
                    r_k <= r_k + 3'd1;
                end
            end
            isr_pkg::BS_CAPTURE: begin
                if (r_lmode == isr_pkg::LM_RX_RD) begin
                    r_rbyte <= w_cap;
                end else begin
                    r_frame[{~w_put, 3'b000} +: 8] <= w_cap;
                end
                r_k <= r_k + 3'd1;
            end
            default: ;
        endcase
        // result register load
        if (w_res_load) begin
            r_res.status    <= r_status;
            r_res.tx_valid  <= r_emit;
            r_res.tx_frame  <= r_emit ? r_frame : 64'd0;
            r_res.tx_can_id <= r_emit ? i_send_id : 29'd0;
            r_res.rx_ready  <= w_rx_rdy;
            r_res.rx_length <= r_released ? r_rel_len : (w_rx_rdy ? r_rx_total : 12'd0);
            r_res.read_byte <= r_rbyte;
            r_res.tx_busy   <= (r_tx_ph != isr_pkg::TXP_IDLE);
        end
    end

    // protocol state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_ph       <= isr_pkg::TXP_IDLE;
            r_tx_total    <= 16'd0;
            r_tx_done     <= 16'd0;
            r_tx_seq      <= 4'd0;
            r_tx_bs       <= 8'd0;
            r_tx_sep      <= 8'd0;
            r_tx_fc_stamp <= 32'd0;
            r_tx_cf_stamp <= 32'd0;
            r_rx_ph       <= isr_pkg::RXP_IDLE;
            r_rx_total    <= 12'd0;
            r_rx_got      <= 12'd0;
            r_rx_seq      <= 4'd0;
            r_rx_stamp    <= 32'd0;
            r_now         <= 32'd0;
        end else if (r_state == isr_pkg::BS_DECODE) begin
            case (r_job.cmd)
                isr_pkg::CMD_TICK: begin
                    r_now <= w_nowp;
                    if (r_tx_ph == isr_pkg::TXP_SEND_CF && w_cf_due) begin
                        r_tx_done     <= w_tx_done_nx;
                        r_tx_seq      <= r_tx_seq + 4'd1;
                        r_tx_cf_stamp <= w_nowp;
                        if (w_tx_done_nx >= r_tx_total) begin
                            r_tx_ph <= isr_pkg::TXP_IDLE;
                        end
                    end else if (r_tx_ph == isr_pkg::TXP_WAIT_FC && w_fc_to) begin
                        r_tx_ph    <= isr_pkg::TXP_IDLE;
                        r_tx_total <= 16'd0;
                        r_tx_done  <= 16'd0;
                        r_tx_seq   <= 4'd0;
                        r_tx_bs    <= 8'd0;
                        r_tx_sep   <= 8'd0;
                    end
                    if (r_rx_ph == isr_pkg::RXP_RECV && w_rx_to) begin
                        r_rx_ph    <= isr_pkg::RXP_IDLE;
                        r_rx_total <= 12'd0;
                        r_rx_got   <= 12'd0;
                        r_rx_seq   <= 4'd0;
                    end
                end
                isr_pkg::CMD_RX_FRAME: begin
                    case (w_ptype)
                        isr_pkg::PCI_SF: begin
                            if (w_low != 4'd0 && w_low <= 4'd7) begin
                                r_rx_ph    <= isr_pkg::RXP_IDLE;
                                r_rx_total <= {8'd0, w_low};
                                r_rx_got   <= {8'd0, w_low};
                                r_rx_seq   <= 4'd0;
                            end
                        end
                        isr_pkg::PCI_FF: begin
                            if (w_ff_len >= 12'd8 && {5'd0, w_ff_len} <= BUF_L) begin
                                r_rx_ph    <= isr_pkg::RXP_RECV;
                                r_rx_total <= w_ff_len;
                                r_rx_got   <= 12'd6;
                                r_rx_seq   <= 4'd1;
                                r_rx_stamp <= r_now;
                            end
                        end
                        isr_pkg::PCI_CF: begin
                            if (r_rx_ph == isr_pkg::RXP_RECV) begin
                                if (w_low != r_rx_seq) begin
                                    r_rx_ph    <= isr_pkg::RXP_IDLE;
                                    r_rx_total <= 12'd0;
                                    r_rx_got   <= 12'd0;
                                    r_rx_seq   <= 4'd0;
                                end else begin
                                    r_rx_got   <= w_rx_got_nx;
                                    r_rx_seq   <= r_rx_seq + 4'd1;
                                    r_rx_stamp <= r_now;
                                    if (w_rx_got_nx >= r_rx_total) begin
                                        r_rx_ph <= isr_pkg::RXP_IDLE;
                                    end
                                end
                            end
                        end
                        isr_pkg::PCI_FC: begin
                            if (r_tx_ph == isr_pkg::TXP_WAIT_FC) begin
                                r_tx_bs  <= w_d[55:48];
                                r_tx_sep <= w_d[47:40];
                                if (w_low == isr_pkg::FC_CTS) begin
                                    r_tx_ph       <= isr_pkg::TXP_SEND_CF;
                                    r_tx_cf_stamp <= r_now;
                                end else if (w_low == isr_pkg::FC_ABORT) begin
                                    r_tx_ph    <= isr_pkg::TXP_IDLE;
                                    r_tx_total <= 16'd0;
                                    r_tx_done  <= 16'd0;
                                    r_tx_seq   <= 4'd0;
                                    r_tx_bs    <= 8'd0;
                                    r_tx_sep   <= 8'd0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                isr_pkg::CMD_START: begin
                    if (r_job.item.length_value != 16'd0
                        && r_job.item.length_value <= MAX_SEND
                        && r_tx_ph == isr_pkg::TXP_IDLE) begin
                        r_tx_total <= r_job.item.length_value;
                        r_tx_done  <= 16'd0;
                        if (r_job.item.length_value > 16'd7) begin
                            r_tx_done     <= 16'd6;
                            r_tx_seq      <= 4'd1;
                            r_tx_ph       <= isr_pkg::TXP_WAIT_FC;
                            r_tx_fc_stamp <= r_now;
                        end
                    end
                end
                isr_pkg::CMD_RELEASE: begin
                    if (w_rx_rdy && {4'd0, r_rx_total} <= r_job.item.length_value) begin
                        r_rx_ph    <= isr_pkg::RXP_IDLE;
                        r_rx_total <= 12'd0;
                        r_rx_got   <= 12'd0;
                        r_rx_seq   <= 4'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_load) begin
            r_res_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_out.valid   = r_res_valid;
    assign o_out.payload = r_res;

endmodule

/* rtl/isotp_segment_reassemble_link.sv */
// ----------------------------------------------------------------------------
// isotp_segment_reassemble_link
// iso-tp send and receive engine over 8-byte can frames with apb registers
// ----------------------------------------------------------------------------
// each word passes idle, decode, issue and result, plus an issue per byte written
// or an issue and capture per byte read; one word at a time through the single-port loop
// a 2-deep job queue lets the next word be taken while the engine works
// reset: synchronous active low; clears link state, counters, queue and output
// byte buffers hold no reset, send_id resets to 0 and timeout to 1000 ms
module isotp_segment_reassemble_link #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isr_in_if.sink      i_in,
    isr_out_if.source   o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    isr_pkg::t_job w_job;
    logic          w_job_valid;
    logic          w_job_pop;
    logic [28:0]   r_send_id;
    logic [15:0]   r_timeout;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_id <= 29'd0;
            r_timeout <= 16'd1000;
        end else if (i_psel && i_penable && i_pwrite) begin
            if (i_paddr[2]) begin
                r_timeout <= i_pwdata[15:0];
            end else begin
                r_send_id <= i_pwdata[28:0];
            end
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[2] ? {16'd0, r_timeout} : {3'd0, r_send_id};

    isr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop)
    );

    isr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_send_id   (r_send_id),
        .i_timeout   (r_timeout),
        .o_out       (o_out)
    );

    // no frame content without a frame
    a_idle_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.payload.tx_valid |-> o_out.payload.tx_frame == 64'd0)
        else $error("frame bits set with no frame emitted");

    // failed commands never emit
    a_fail_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.status != isr_pkg::ST_OK |-> !o_out.payload.tx_valid)
        else $error("frame emitted on a failed command");

    // a waiting message always has a length
    a_ready_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.rx_ready |-> o_out.payload.rx_length != 12'd0)
        else $error("received message ready with zero length");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the iso-tp link engine word by word. Input words go into the block
// in order. A behavioural copy of the send and receive state machines works
// out the result word for each input word as it is accepted. Each result that
// comes out is compared field by field with the oldest expected word. The
// stimulus is a short directed list, then random phases with different
// register settings: mostly well-formed receive and send exchanges with random
// content, mixed with noise words.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] RAW_SPARE6  = 3'd6;
    localparam logic [2:0] RAW_SPARE7  = 3'd7;
    localparam int         REG_SEND_ID = 0;
    localparam int         REG_TIMEOUT = 1;
    localparam int         MEM_BYTES   = 4096;
    localparam int         STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    isr_in_if  link_in ();
    isr_out_if link_out ();

    isotp_segment_reassemble_link uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (link_in),
        .o_out     (link_out),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #2 i_clk = ~i_clk;

    // link state as the checker sees it
    logic [7:0]  tx_mem [MEM_BYTES];
    logic [7:0]  rx_mem [MEM_BYTES];
    isr_pkg::t_txph tx_ph;
    isr_pkg::t_rxph rx_ph;
    int unsigned tx_total, tx_done, tx_seq, tx_bs, tx_st, fc_stamp, cf_stamp;
    int unsigned rx_total, rx_got, rx_seq, rx_stamp, now_ms;
    logic [28:0] cfg_id;
    logic [15:0] cfg_tmo;
    int unsigned rx_hi;

    isr_pkg::t_in_item  pending_words [$];
    isr_pkg::t_out_item resp_q [$];
    int          errors = 0;
    int unsigned cyc = 0;
    int unsigned stall = 0;

    // stimulus bookkeeping
    bit          tx_w [MEM_BYTES];
    int unsigned tx_pre = 0;
    int unsigned gen_rx_hi = 0;
    int unsigned gen_count = 0;

    function automatic bit rx_done_msg();
        return rx_ph == isr_pkg::RXP_IDLE && rx_got > 0 && rx_total > 0;
    endfunction

    function automatic logic [63:0] fc_frame(logic [3:0] flag);
        logic [63:0] f;
        f = isr_pkg::PAD_FRAME;
        f[63:56] = {isr_pkg::PCI_FC, flag};
        f[55:40] = '0;
        return f;
    endfunction

    function automatic void clear_tx();
        tx_ph = isr_pkg::TXP_IDLE;
        tx_total = 0;
        tx_done = 0;
        tx_seq = 0;
        tx_bs = 0;
        tx_st = 0;
    endfunction

    function automatic void clear_rx();
        rx_ph = isr_pkg::RXP_IDLE;
        rx_total = 0;
        rx_got = 0;
        rx_seq = 0;
    endfunction

    function automatic void rx_put(int unsigned idx, logic [7:0] v);
        rx_mem[idx] = v;
        if (idx + 1 > rx_hi && idx <= rx_hi) rx_hi = idx + 1;
    endfunction

    // expected result word for one accepted input word
    function automatic isr_pkg::t_out_item link_step(isr_pkg::t_in_item it);
        isr_pkg::t_out_item r;
        logic [63:0] f;
        logic [63:0] d;
        logic [3:0]  low;
        int unsigned n, len, k, rel_len;
        bit          emitted, released;
        r = '0;
        f = '0;
        d = it.frame_data;
        low = d[59:56];
        emitted = 0;
        released = 0;
        rel_len = 0;
        case (it.command)
            isr_pkg::RAW_TICK: begin
                now_ms = now_ms + 1;
                if (tx_ph == isr_pkg::TXP_SEND_CF && now_ms - cf_stamp >= tx_st) begin
                    n = (tx_total > tx_done) ? tx_total - tx_done : 0;
                    if (n > 7) n = 7;
                    f = isr_pkg::PAD_FRAME;
                    f[63:56] = {isr_pkg::PCI_CF, tx_seq[3:0]};
                    for (k = 0; k < n; k++)
                        f[55 - 8 * k -: 8] = tx_mem[tx_done + k];
                    tx_done = (tx_done + n) & 16'hFFFF;
                    tx_seq = (tx_seq + 1) & 4'hF;
                    if (tx_done >= tx_total) tx_ph = isr_pkg::TXP_IDLE;
                    emitted = 1;
                    cf_stamp = now_ms;
                end
                if (tx_ph == isr_pkg::TXP_WAIT_FC && now_ms - fc_stamp >= cfg_tmo) clear_tx();
                if (rx_ph == isr_pkg::RXP_RECV && now_ms - rx_stamp >= cfg_tmo) clear_rx();
            end
            isr_pkg::RAW_RX: begin
                if (it.frame_length != 0) begin
                    case (d[63:60])
                        isr_pkg::PCI_SF: begin
                            if (low != 0 && low <= 7) begin
                                for (k = 0; k < low; k++) rx_put(k, d[55 - 8 * k -: 8]);
                                clear_rx();
                                rx_total = low;
                                rx_got = low;
                            end
                        end
                        isr_pkg::PCI_FF: begin
                            len = {low, d[55:48]};
                            if (len >= 8 && len > MEM_BYTES) begin
                                f = fc_frame(isr_pkg::FC_ABORT);
                                emitted = 1;
                            end else if (len >= 8) begin
                                clear_rx();
                                rx_total = len;
                                for (k = 0; k < 6; k++) rx_put(k, d[47 - 8 * k -: 8]);
                                rx_got = 6;
                                rx_seq = 1;
                                rx_ph = isr_pkg::RXP_RECV;
                                rx_stamp = now_ms;
                                f = fc_frame(isr_pkg::FC_CTS);
                                emitted = 1;
                            end
                        end
                        isr_pkg::PCI_CF: begin
                            if (rx_ph == isr_pkg::RXP_RECV) begin
                                if (low != rx_seq[3:0]) begin
                                    clear_rx();
                                end else begin
                                    len = (rx_total > rx_got) ? rx_total - rx_got : 0;
                                    if (len > 7) len = 7;
                                    for (k = 0; k < len; k++)
                                        if (rx_got + k < MEM_BYTES)
                                            rx_put(rx_got + k, d[55 - 8 * k -: 8]);
                                    rx_got = (rx_got + len) & 12'hFFF;
                                    rx_seq = (rx_seq + 1) & 4'hF;
                                    rx_stamp = now_ms;
                                    if (rx_got >= rx_total) rx_ph = isr_pkg::RXP_IDLE;
                                end
                            end
                        end
                        isr_pkg::PCI_FC: begin
                            if (tx_ph == isr_pkg::TXP_WAIT_FC) begin
                                tx_bs = d[55:48];
                                tx_st = d[47:40];
                                if (low == isr_pkg::FC_CTS) begin
                                    tx_ph = isr_pkg::TXP_SEND_CF;
                                    cf_stamp = now_ms;
                                end else if (low == isr_pkg::FC_ABORT) begin
                                    clear_tx();
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            isr_pkg::RAW_LOAD: tx_mem[it.byte_index] = it.byte_value;
            isr_pkg::RAW_START: begin
                len = it.length_value;
                if (len == 0) r.status = isr_pkg::ST_ERROR;
                else if (len > 4095) r.status = isr_pkg::ST_OVERFLOW;
                else if (tx_ph != isr_pkg::TXP_IDLE) r.status = isr_pkg::ST_BUSY;
                else begin
                    tx_total = len;
                    tx_done = 0;
                    f = isr_pkg::PAD_FRAME;
                    if (len <= 7) begin
                        f[63:56] = len[7:0];
                        for (k = 0; k < len; k++) f[55 - 8 * k -: 8] = tx_mem[k];
                    end else begin
                        f[63:56] = {isr_pkg::PCI_FF, len[11:8]};
                        f[55:48] = len[7:0];
                        for (k = 0; k < 6; k++) f[47 - 8 * k -: 8] = tx_mem[k];
                        tx_done = 6;
                        tx_seq = 1;
                        tx_ph = isr_pkg::TXP_WAIT_FC;
                        fc_stamp = now_ms;
                    end
                    emitted = 1;
                end
            end
            isr_pkg::RAW_READ: r.read_byte = rx_mem[it.byte_index];
            isr_pkg::RAW_RELEASE: begin
                if (!rx_done_msg()) r.status = isr_pkg::ST_NO_DATA;
                else if (rx_total > it.length_value) r.status = isr_pkg::ST_OVERFLOW;
                else begin
                    released = 1;
                    rel_len = rx_total;
                    clear_rx();
                end
            end
            default: r.status = isr_pkg::ST_ERROR;
        endcase
        r.tx_valid = emitted;
        r.tx_frame = emitted ? f : '0;
        r.tx_can_id = emitted ? cfg_id : '0;
        r.rx_ready = rx_done_msg();
        r.rx_length = released ? rel_len[11:0] : (rx_done_msg() ? rx_total[11:0] : 12'd0);
        r.tx_busy = tx_ph != isr_pkg::TXP_IDLE;
        return r;
    endfunction

    // input word driver
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            link_in.valid <= 1'b0;
        end else begin
            if (link_in.valid && link_in.ready)
                resp_q.push_back(link_step(link_in.payload));
            if (!link_in.valid || link_in.ready) begin
                if (pending_words.size() != 0 &&
                    (($urandom_range(99) >= 16) || (cyc >= 4000 && cyc < 7000))) begin
                    link_in.valid <= 1'b1;
                    link_in.payload <= pending_words.pop_front();
                end else begin
                    link_in.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
            errors++;
        end
    endtask

    // result word monitor
    always @(posedge i_clk) begin
        isr_pkg::t_out_item want;
        isr_pkg::t_out_item got;
        if (!i_rst_n) begin
            link_out.ready <= 1'b0;
        end else begin
            if (link_out.valid && link_out.ready) begin
                got = link_out.payload;
                if (resp_q.size() == 0) begin
                    $display("%0t: unexpected word expected none actual %h", $realtime, got);
                    errors++;
                end else begin
                    want = resp_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_frame", want.tx_frame, got.tx_frame);
                    check_field("tx_can_id", want.tx_can_id, got.tx_can_id);
                    check_field("rx_ready", want.rx_ready, got.rx_ready);
                    check_field("rx_length", want.rx_length, got.rx_length);
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("tx_busy", want.tx_busy, got.tx_busy);
                end
            end
            link_out.ready <= ($urandom_range(99) >= 16) || (cyc >= 4000 && cyc < 7000);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((link_in.valid && link_in.ready) || (link_out.valid && link_out.ready))
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= STALL_LIMIT) begin
            $display("isotp_segment_reassemble_link: mismatch");
            $finish;
        end
    end

    function automatic void put_word(logic [2:0] cmd, logic [63:0] data, logic [3:0] flen,
                                     logic [11:0] idx, logic [7:0] bval, logic [15:0] lval);
        isr_pkg::t_in_item it;
        it.command = cmd;
        it.frame_data = data;
        it.frame_length = flen;
        it.byte_index = idx;
        it.byte_value = bval;
        it.length_value = lval;
        pending_words.push_back(it);
        gen_count++;
        if (cmd == isr_pkg::RAW_LOAD) begin
            tx_w[idx] = 1;
            while (tx_pre < MEM_BYTES && tx_w[tx_pre]) tx_pre++;
        end
        if (cmd == isr_pkg::RAW_RX && flen != 0 && data[63:60] == isr_pkg::PCI_SF &&
            data[59:56] != 0 && data[59:56] <= 7 && data[59:56] > gen_rx_hi)
            gen_rx_hi = data[59:56];
        if (cmd == isr_pkg::RAW_RX && flen != 0 && data[63:60] == isr_pkg::PCI_FF &&
            data[59:48] >= 8 && gen_rx_hi < 6)
            gen_rx_hi = 6;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic void tick_words(int unsigned n);
        for (int unsigned k = 0; k < n; k++) put_word(isr_pkg::RAW_TICK, rnd64(), 0, 0, 0, 0);
    endfunction

    function automatic void read_word();
        if (gen_rx_hi > 0)
            put_word(isr_pkg::RAW_READ, 0, 0, $urandom_range(gen_rx_hi - 1), 0, 0);
        else
            tick_words(1);
    endfunction

    // a full received message: sf, or ff plus cfs, then reads and release
    function automatic void rx_exchange();
        logic [63:0] f;
        int unsigned len, n;
        f = rnd64();
        if ($urandom_range(3) == 0) begin
            len = $urandom_range(1, 7);
            f[63:56] = {isr_pkg::PCI_SF, len[3:0]};
            put_word(isr_pkg::RAW_RX, f, $urandom_range(1, 8), 0, 0, 0);
        end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 400) : $urandom_range(8, 60);
            f[63:48] = {isr_pkg::PCI_FF, len[11:0]};
            put_word(isr_pkg::RAW_RX, f, 8, 0, 0, 0);
            n = (len - 6 + 6) / 7;
            for (int unsigned k = 1; k <= n; k++) begin
                f = rnd64();
                f[63:56] = {isr_pkg::PCI_CF, k[3:0]};
                if ($urandom_range(39) == 0) f[59:56] = f[59:56] + 1;
                if ($urandom_range(19) == 0) tick_words(1);
                put_word(isr_pkg::RAW_RX, f, $urandom_range(1, 8), 0, 0, 0);
            end
        end
        for (int k = $urandom_range(3); k > 0; k--) read_word();
        put_word(isr_pkg::RAW_RELEASE, 0, 0, 0, 0,
                 ($urandom_range(4) == 0) ? len - 1 : $urandom_range(len, 65535));
        if ($urandom_range(2) == 0) put_word(isr_pkg::RAW_RELEASE, 0, 0, 0, 0, 16'hFFFF);
    endfunction

    // a full send: loads, start, flow control and enough ticks to finish
    function automatic void tx_exchange();
        logic [63:0] f;
        int unsigned len, lmax, n, st, pick;
        for (int k = $urandom_range(8); k > 0; k--)
            put_word(isr_pkg::RAW_LOAD, 0, 0, tx_pre < MEM_BYTES ? tx_pre : 0,
                     $urandom_range(255), 0);
        lmax = tx_pre > 4095 ? 4095 : tx_pre;
        if ($urandom_range(6) == 0) len = $urandom_range(8, lmax);
        else if ($urandom_range(3) == 0) len = $urandom_range(1, 7);
        else len = $urandom_range(8, lmax > 60 ? 60 : lmax);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, len);
        if (len <= 7) return;
        n = (len - 6 + 6) / 7;
        st = (len > 200) ? 0 : $urandom_range(3);
        pick = $urandom_range(9);
        f = rnd64();
        f[47:40] = st[7:0];
        if (pick == 0 && cfg_tmo <= 10) begin
            tick_words(cfg_tmo + 1);
            return;
        end
        if (pick == 1) begin
            f[63:56] = {isr_pkg::PCI_FC, isr_pkg::FC_ABORT};
            put_word(isr_pkg::RAW_RX, f, 3, 0, 0, 0);
            return;
        end
        if (pick == 2) begin
            f[63:56] = {isr_pkg::PCI_FC, 4'h1};
            put_word(isr_pkg::RAW_RX, f, 3, 0, 0, 0);
        end
        f[63:56] = {isr_pkg::PCI_FC, isr_pkg::FC_CTS};
        put_word(isr_pkg::RAW_RX, f, 3, 0, 0, 0);
        if ($urandom_range(4) == 0) put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 1);
        tick_words(n * (st + 1) + 1);
    endfunction

    function automatic void noise_word();
        logic [2:0]  cmd;
        logic [15:0] lval;
        cmd = $urandom_range(7);
        lval = $urandom_range(65535);
        if (cmd == isr_pkg::RAW_READ) begin
            read_word();
            return;
        end
        if (cmd == isr_pkg::RAW_START && lval != 0 && lval <= 4095 && lval > tx_pre)
            lval = $urandom_range(1, tx_pre);
        put_word(cmd, rnd64(), $urandom_range(8), $urandom_range(4095),
                 $urandom_range(255), lval);
    endfunction

    task automatic write_reg(int idx, logic [31:0] val);
        @(posedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= 3'(idx * 4);
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        if (idx == REG_SEND_ID) cfg_id = val[28:0];
        else cfg_tmo = val[15:0];
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || link_in.valid || resp_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] f;
        int unsigned target;
        link_in.valid = 1'b0;
        link_in.payload = '0;
        link_out.ready = 1'b0;
        clear_tx();
        clear_rx();
        fc_stamp = 0;
        cf_stamp = 0;
        rx_stamp = 0;
        now_ms = 0;
        rx_hi = 0;
        cfg_id = '0;
        cfg_tmo = 16'd1000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: buffer edges, bad commands, sends and receives
        for (int k = 0; k < 16; k++)
            put_word(isr_pkg::RAW_LOAD, 0, 0, k, k == 0 ? 8'h00 : 8'hFF - k, 0);
        put_word(isr_pkg::RAW_LOAD, 0, 0, 12'hFFF, 8'hFF, 0);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 0);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 16'hFFFF);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 16'd4096);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 3);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 10);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 5);
        put_word(isr_pkg::RAW_RX, {isr_pkg::PCI_FC, 4'h1, 8'h05, 8'h02, 40'h0}, 3, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, {isr_pkg::PCI_FC, isr_pkg::FC_CTS, 8'h00, 8'h00, 40'h0},
                 3, 0, 0, 0);
        tick_words(2);
        put_word(isr_pkg::RAW_RX, 64'h05_11_22_33_44_55_66_77, 6, 0, 0, 0);
        put_word(isr_pkg::RAW_READ, 0, 0, 4, 0, 0);
        put_word(isr_pkg::RAW_RELEASE, 0, 0, 0, 0, 4);
        put_word(isr_pkg::RAW_RELEASE, 0, 0, 0, 0, 5);
        put_word(isr_pkg::RAW_RELEASE, 0, 0, 0, 0, 5);
        put_word(isr_pkg::RAW_RX, 64'h03_01_02_03_00_00_00_00, 0, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, 64'h00_00_00_00_00_00_00_00, 8, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, 64'h08_00_00_00_00_00_00_00, 8, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, 64'h10_07_00_00_00_00_00_00, 8, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, 64'h21_00_00_00_00_00_00_00, 8, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, 64'h1F_FF_01_02_03_04_05_06, 8, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, 64'h23_00_00_00_00_00_00_00, 8, 0, 0, 0);
        put_word(isr_pkg::RAW_RX, 64'hF0_FF_FF_FF_FF_FF_FF_FF, 8, 0, 0, 0);
        put_word(RAW_SPARE6, 0, 0, 0, 0, 0);
        put_word(RAW_SPARE7, 0, 0, 0, 0, 0);
        put_word(isr_pkg::RAW_START, 0, 0, 0, 0, 12);
        put_word(isr_pkg::RAW_RX, {isr_pkg::PCI_FC, isr_pkg::FC_ABORT, 16'h0, 40'h0},
                 3, 0, 0, 0);

        // random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                1: begin
                    write_reg(REG_SEND_ID, 32'h1FFF_FFFF);
                    write_reg(REG_TIMEOUT, 32'd1);
                end
                2: begin
                    write_reg(REG_SEND_ID, $urandom);
                    write_reg(REG_TIMEOUT, 32'd3);
                end
                3: begin
                    write_reg(REG_SEND_ID, 32'h0);
                    write_reg(REG_TIMEOUT, 32'hFFFF);
                end
                4: begin
                    write_reg(REG_SEND_ID, $urandom);
                    write_reg(REG_TIMEOUT, 32'd2);
                end
                default: ;
            endcase
            if (rx_hi > gen_rx_hi) gen_rx_hi = rx_hi;
            target = gen_count + 225;
            while (gen_count < target) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: rx_exchange();
                    4, 5, 6:    tx_exchange();
                    default:    for (int k = 0; k < 5; k++) noise_word();
                endcase
            end
        end

        wait_idle();
        if (errors == 0)
            $display("isotp_segment_reassemble_link: match");
        else
            $display("isotp_segment_reassemble_link: mismatch");
        $finish;
    end
endmodule
